/* rtl/core/cwts_pkg.sv */
// ----------------------------------------------------------------------------
// cwts_pkg: shared types and constants of the cascaded window timing stats
// Item and result formats, table entry layouts and window limits.
// ----------------------------------------------------------------------------
`default_nettype none

package cwts_pkg;

    localparam int TOTAL_W = 48;
    localparam int CALLS_W = 32;
    localparam int PEAK_W  = 32;
    localparam int TIME_W  = 40;
    localparam int CFG_W   = 16;

    localparam logic [1:0] FN_SAMPLE = 2'd0;
    localparam logic [1:0] FN_POLL   = 2'd1;
    localparam logic [1:0] FN_READ   = 2'd2;
    localparam logic [1:0] FN_CLEAR  = 2'd3;

    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_LIMIT  = 1'b1;

    localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd1000;
    localparam logic [CFG_W-1:0] LIMIT_RESET  = 16'd1500;

    typedef struct packed {
        logic [1:0]        func;
        logic [3:0]        script_id;
        logic [3:0]        event_id;
        logic [31:0]       sample_us;
        logic [TIME_W-1:0] now_ms;
        logic [1:0]        window_sel;
        logic              script_row;
    } t_item;

    typedef struct packed {
        logic [CALLS_W-1:0] call_count;
        logic [TOTAL_W-1:0] sum_us;
        logic [PEAK_W-1:0]  peak_us;
        logic               significant;
        logic               ticked;
    } t_result;

    typedef struct packed {
        logic [CALLS_W-1:0] calls;
        logic [TOTAL_W-1:0] total;
        logic [PEAK_W-1:0]  peak;
    } t_ev_stat;

    typedef struct packed {
        t_ev_stat acc;
        t_ev_stat prev;
    } t_ev_entry;

    typedef struct packed {
        logic [TOTAL_W-1:0] acc;
        logic [TOTAL_W-1:0] prev;
    } t_sc_entry;

    typedef struct packed {
        logic       tick;
        logic [3:0] due;
    } t_tick_info;

    function automatic logic [TOTAL_W-1:0] win_limit(input logic [1:0] w);
        logic [TOTAL_W-1:0] v;
        case (w)
            2'd0:    v = 48'd5000;
            2'd1:    v = 48'd60000;
            2'd2:    v = 48'd300000;
            default: v = 48'd3600000;
        endcase
        return v;
    endfunction

    function automatic logic [TOTAL_W-1:0] sat_total(input logic [TOTAL_W-1:0] a,
                                                     input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TOTAL_W] ? {TOTAL_W{1'b1}} : s[TOTAL_W-1:0];
    endfunction

    function automatic logic [CALLS_W-1:0] sat_calls(input logic [CALLS_W-1:0] a,
                                                     input logic [CALLS_W-1:0] b);
        logic [CALLS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CALLS_W] ? {CALLS_W{1'b1}} : s[CALLS_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/cwts_ram.sv */
// ----------------------------------------------------------------------------
// cwts_ram: single write port, single read port synchronous memory
// Read data is registered and appears in the cycle after the read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module cwts_ram #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int WIDTH = 224
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cwts_timebase.sv */
// ----------------------------------------------------------------------------
// cwts_timebase: second tick generator and window due logic
// Tracks the tick base in milliseconds and the second counter as a
// mixed-radix count of 5, 12, 5 and 12 that wraps every 3600 ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module cwts_timebase (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_poll,
    input  wire logic [cwts_pkg::TIME_W-1:0]   i_now,
    input  wire logic [cwts_pkg::CFG_W-1:0]    i_period,
    input  wire logic [cwts_pkg::CFG_W-1:0]    i_limit,
    output cwts_pkg::t_tick_info               o_tick
);

    import cwts_pkg::*;

    logic [TIME_W-1:0] r_last;
    logic [2:0]        r_m5;
    logic [3:0]        r_m12;
    logic [2:0]        r_m5b;
    logic [3:0]        r_m12b;

    logic [TIME_W:0]   diff;
    logic [TIME_W:0]   floor_ms;
    logic [TIME_W-1:0] last_inc;
    logic [TIME_W-1:0] n_last;
    logic              tick;
    logic [3:0]        due;

    always_comb begin
        diff     = {1'b0, i_now} - {1'b0, r_last};
        tick     = !diff[TIME_W] && (diff[TIME_W-1:0] >= TIME_W'(i_period));
        last_inc = r_last + TIME_W'(i_period);
        floor_ms = {1'b0, i_now} - (TIME_W+1)'(i_limit);
        n_last   = (!floor_ms[TIME_W] && (floor_ms[TIME_W-1:0] > last_inc)) ?
                   floor_ms[TIME_W-1:0] : last_inc;
        due[0]   = (r_m5 == 3'd4);
        due[1]   = due[0] && (r_m12 == 4'd11);
        due[2]   = due[1] && (r_m5b == 3'd4);
        due[3]   = due[2] && (r_m12b == 4'd11);
        o_tick.tick = tick;
        o_tick.due  = due;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_m5   <= '0;
            r_m12  <= '0;
            r_m5b  <= '0;
            r_m12b <= '0;
        end else if (i_poll && tick) begin
            r_last <= n_last;
            r_m5   <= due[0] ? 3'd0 : r_m5 + 3'd1;
            if (due[0]) begin
                r_m12 <= due[1] ? 4'd0 : r_m12 + 4'd1;
            end
            if (due[1]) begin
                r_m5b <= due[2] ? 3'd0 : r_m5b + 3'd1;
            end
            if (due[2]) begin
                r_m12b <= due[3] ? 4'd0 : r_m12b + 4'd1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cascaded_window_timing_stats_core.sv */
// ----------------------------------------------------------------------------
// cascaded_window_timing_stats_core: profiling table over four windows
// Command-driven statistics table held in an event memory and a script memory.
// ----------------------------------------------------------------------------
// Usage: an item is taken when start is high and busy is low. Every item
// gives exactly one result on o_result, marked by o_valid for one cycle,
// registered in S_RMW after the transfer; the receiver cannot stall it.
// A sample, a read, a poll without tick and a clear of an invalid script
// end in the S_RMW state, once the registered read of the memories that
// comes before the write back is done. A poll that ticks then walks every
// event entry once, one per cycle; a clear of a valid script then writes
// its entries. After reset busy stays high for a clearing pass that zeroes
// both memories. Configuration writes on i_cfg_we are taken at any edge
// and are meant to happen only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cascaded_window_timing_stats_core #(
    parameter int SCRIPTS           = 16,
    parameter int EVENTS_PER_SCRIPT = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire cwts_pkg::t_item             i_item,
    output logic                             o_valid,
    output cwts_pkg::t_result                o_result,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_idx,
    input  wire logic [cwts_pkg::CFG_W-1:0]  i_cfg_wdata
);

    import cwts_pkg::*;

    localparam int EV_ROWS  = SCRIPTS * EVENTS_PER_SCRIPT;
    localparam int ERW      = (EV_ROWS > 1) ? $clog2(EV_ROWS) : 1;
    localparam int SRW      = (SCRIPTS > 1) ? $clog2(SCRIPTS) : 1;
    localparam int EV_AW    = ERW + 2;
    localparam int SC_AW    = SRW + 2;
    localparam int EV_DEPTH = EV_ROWS * 4;
    localparam int SC_DEPTH = SCRIPTS * 4;
    localparam int EV_CLR   = EVENTS_PER_SCRIPT * 4;
    localparam int EW       = $bits(t_ev_entry);
    localparam int SW       = $bits(t_sc_entry);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_RMW   = 5'b00100,
        S_WALK  = 5'b01000,
        S_ZERO  = 5'b10000
    } t_state;

    t_state            r_state;
    t_item             r_item;
    logic [EV_AW:0]    r_idx;
    logic              r_pend;
    logic              r_sc_pend;
    logic [EV_AW-1:0]  r_wadr;
    logic [3:0]        r_due;
    t_ev_stat          r_ev_carry;
    logic [TOTAL_W-1:0] r_sc_carry;
    logic [CFG_W-1:0]  r_period;
    logic [CFG_W-1:0]  r_limit;
    logic              r_valid;
    t_result           r_res;

    logic              ev_we, ev_re, sc_we, sc_re;
    logic [EV_AW-1:0]  ev_waddr, ev_raddr;
    logic [SC_AW-1:0]  sc_waddr, sc_raddr;
    t_ev_entry         ev_wdata, ev_rdata;
    t_sc_entry         sc_wdata, sc_rdata;

    logic              accept, poll;
    logic              vs, ve;
    logic [ERW-1:0]    row_in, row_cur, sid_base;
    logic [SRW-1:0]    srow_in, srow_cur;
    logic [1:0]        w_in;
    t_tick_info        tick;
    t_result           res;
    logic [1:0]        ww;
    logic              due_w, dprev;
    t_ev_stat          ev_a;
    logic [TOTAL_W-1:0] sc_a;
    logic [TOTAL_W-1:0] rd_total;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);
    assign poll   = (r_state == S_RMW) && (r_item.func == FN_POLL);

    cwts_timebase u_timebase (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_poll   (poll),
        .i_now    (r_item.now_ms),
        .i_period (r_period),
        .i_limit  (r_limit),
        .o_tick   (tick)
    );

    cwts_ram #(.DEPTH(EV_DEPTH), .AW(EV_AW), .WIDTH(EW)) u_ev_ram (
        .i_clk   (i_clk),
        .i_we    (ev_we),
        .i_waddr (ev_waddr),
        .i_wdata (ev_wdata),
        .i_re    (ev_re),
        .i_raddr (ev_raddr),
        .o_rdata (ev_rdata)
    );

    cwts_ram #(.DEPTH(SC_DEPTH), .AW(SC_AW), .WIDTH(SW)) u_sc_ram (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (sc_wdata),
        .i_re    (sc_re),
        .i_raddr (sc_raddr),
        .o_rdata (sc_rdata)
    );

    always_comb begin
        vs       = (int'(r_item.script_id) < SCRIPTS);
        ve       = (int'(r_item.event_id) < EVENTS_PER_SCRIPT);
        row_in   = ERW'(ERW'(i_item.script_id) * ERW'(EVENTS_PER_SCRIPT))
                   + ERW'(i_item.event_id);
        sid_base = ERW'(ERW'(r_item.script_id) * ERW'(EVENTS_PER_SCRIPT));
        row_cur  = sid_base + ERW'(r_item.event_id);
        srow_in  = SRW'(i_item.script_id);
        srow_cur = SRW'(r_item.script_id);
        w_in     = (i_item.func == FN_READ) ? i_item.window_sel : 2'd0;

        ww    = r_wadr[1:0];
        due_w = r_due[ww];
        dprev = (ww != 2'd0) && r_due[ww - 2'd1];
        ev_a.calls = dprev ? sat_calls(ev_rdata.acc.calls, r_ev_carry.calls)
                           : ev_rdata.acc.calls;
        ev_a.total = dprev ? sat_total(ev_rdata.acc.total, r_ev_carry.total)
                           : ev_rdata.acc.total;
        ev_a.peak  = (dprev && (r_ev_carry.peak > ev_rdata.acc.peak)) ?
                     r_ev_carry.peak : ev_rdata.acc.peak;
        sc_a = dprev ? sat_total(sc_rdata.acc, r_sc_carry) : sc_rdata.acc;

        ev_we    = 1'b0;
        ev_waddr = r_wadr;
        ev_wdata = '0;
        ev_re    = 1'b0;
        ev_raddr = {row_in, w_in};
        sc_we    = 1'b0;
        sc_waddr = {srow_cur, 2'd0};
        sc_wdata = '0;
        sc_re    = 1'b0;
        sc_raddr = {srow_in, w_in};
        res      = '0;
        rd_total = '0;

        case (r_state)
            S_CLEAR: begin
                ev_we    = 1'b1;
                ev_waddr = r_idx[EV_AW-1:0];
                sc_we    = (r_idx < (EV_AW+1)'(SC_DEPTH));
                sc_waddr = r_idx[SC_AW-1:0];
            end
            S_IDLE: begin
                ev_re = accept;
                sc_re = accept;
            end
            S_RMW: begin
                case (r_item.func)
                    FN_SAMPLE: begin
                        sc_we         = vs;
                        sc_waddr      = {srow_cur, 2'd0};
                        sc_wdata.acc  = sat_total(sc_rdata.acc, TOTAL_W'(r_item.sample_us));
                        sc_wdata.prev = sc_rdata.prev;
                        ev_we          = vs && ve;
                        ev_waddr       = {row_cur, 2'd0};
                        ev_wdata.prev  = ev_rdata.prev;
                        ev_wdata.acc.calls = sat_calls(ev_rdata.acc.calls, 32'd1);
                        ev_wdata.acc.total = sat_total(ev_rdata.acc.total,
                                                       TOTAL_W'(r_item.sample_us));
                        ev_wdata.acc.peak  = (r_item.sample_us > ev_rdata.acc.peak) ?
                                             r_item.sample_us : ev_rdata.acc.peak;
                    end
                    FN_POLL: begin
                        res.ticked = tick.tick;
                    end
                    FN_READ: begin
                        if (vs) begin
                            if (r_item.script_row) begin
                                rd_total = sc_rdata.prev;
                            end else if (ve) begin
                                rd_total       = ev_rdata.prev.total;
                                res.call_count = ev_rdata.prev.calls;
                                res.peak_us    = ev_rdata.prev.peak;
                            end
                        end
                        res.sum_us      = rd_total;
                        res.significant = (rd_total > win_limit(r_item.window_sel));
                    end
                    default: begin
                    end
                endcase
            end
            S_WALK: begin
                ev_re    = (r_idx < (EV_AW+1)'(EV_DEPTH));
                ev_raddr = r_idx[EV_AW-1:0];
                sc_re    = (r_idx < (EV_AW+1)'(SC_DEPTH));
                sc_raddr = r_idx[SC_AW-1:0];
                ev_we    = r_pend;
                ev_waddr = r_wadr;
                sc_we    = r_sc_pend;
                sc_waddr = r_wadr[SC_AW-1:0];
                if (due_w) begin
                    ev_wdata.prev = ev_a;
                    ev_wdata.acc  = '0;
                    sc_wdata.prev = sc_a;
                    sc_wdata.acc  = '0;
                end else begin
                    ev_wdata.prev = ev_rdata.prev;
                    ev_wdata.acc  = ev_a;
                    sc_wdata.prev = sc_rdata.prev;
                    sc_wdata.acc  = sc_a;
                end
            end
            S_ZERO: begin
                ev_we    = 1'b1;
                ev_waddr = {sid_base + ERW'(r_idx[EV_AW:2]), r_idx[1:0]};
                sc_we    = (r_idx < (EV_AW+1)'(4));
                sc_waddr = {srow_cur, r_idx[1:0]};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_idx    <= '0;
            r_pend   <= 1'b0;
            r_sc_pend <= 1'b0;
            r_valid  <= 1'b0;
            r_period <= PERIOD_RESET;
            r_limit  <= LIMIT_RESET;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_PERIOD: r_period <= i_cfg_wdata;
                    CFG_LIMIT:  r_limit  <= i_cfg_wdata;
                    default:    r_period <= r_period;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == (EV_AW+1)'(EV_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_RMW;
                    end
                end
                S_RMW: begin
                    r_valid <= 1'b1;
                    r_idx   <= '0;
                    r_pend  <= 1'b0;
                    r_sc_pend <= 1'b0;
                    if ((r_item.func == FN_POLL) && tick.tick) begin
                        r_state <= S_WALK;
                    end else if ((r_item.func == FN_CLEAR) && vs) begin
                        r_state <= S_ZERO;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_WALK: begin
                    r_pend    <= ev_re;
                    r_sc_pend <= sc_re;
                    if (ev_re) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (!ev_re && !r_pend) begin
                        r_state <= S_IDLE;
                    end
                end
                S_ZERO: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == (EV_AW+1)'(EV_CLR - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_item;
        end
        if (r_state == S_RMW) begin
            r_res <= res;
            r_due <= tick.due;
        end
        if (r_state == S_WALK) begin
            r_wadr <= ev_raddr;
            if (r_pend) begin
                r_ev_carry <= ev_rdata.prev;
            end
            if (r_sc_pend) begin
                r_sc_carry <= sc_rdata.prev;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

`default_nettype wire

/* rtl/core/cwts_checker.sv */
// ----------------------------------------------------------------------------
// cwts_checker: port-level checks of the timing stats core
// Watches the command and result ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cwts_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire logic              o_valid,
    input wire cwts_pkg::t_result o_result
);

    import cwts_pkg::*;

    a_result_follows_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 2))
        else $error("result without a transfer two cycles before");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a transfer");

    a_tick_has_no_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.ticked) |->
        (o_result.sum_us == '0 && o_result.call_count == '0 && !o_result.significant))
        else $error("tick result carries statistics");

    a_significant_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.significant) |-> (o_result.sum_us != '0))
        else $error("significant flag with zero total");

endmodule

bind cascaded_window_timing_stats_core cwts_checker u_cwts_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire
